// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros, included by the request sequencer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define XSBR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define XSBR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define XSBR_ASSERT(label, prop, msg)
`define XSBR_ASSERT_RST(label, prop, msg)
`endif

`endif

// ===== rtl/xsbr_pkg.sv =====
// ---------------------------------------------------------------------------
// xsbr_pkg
// Shared widths, register indexes, shift amounts and helpers.
// ---------------------------------------------------------------------------
package xsbr_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_SEED_ZERO = 1'd0;
  localparam cfg_idx_t REG_SEED_ONE  = 1'd1;

  localparam word_t SEED_ZERO_RST = 64'd1;
  localparam word_t SEED_ONE_RST  = 64'd0;

  localparam int unsigned SHIFT_A = 23;
  localparam int unsigned SHIFT_B = 18;
  localparam int unsigned SHIFT_C = 5;

  typedef struct packed {
    logic  step;
  } gen_ctl_t;

  typedef struct packed {
    word_t sum;
  } gen_sts_t;

  // Smear the highest set bit down to bit zero.
  function automatic word_t length_mask(word_t bound);
    word_t m;
    m = bound;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    m = m | (m >> 32);
    return m;
  endfunction

endpackage

// ===== rtl/xsbr_gen.sv =====
// ---------------------------------------------------------------------------
// xsbr_gen
// Seed registers and xorshift128+ state with a single step unit.
// ---------------------------------------------------------------------------
module xsbr_gen (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  xsbr_pkg::cfg_idx_t cfg_addr,
  input  xsbr_pkg::word_t   cfg_wdata,
  input  xsbr_pkg::gen_ctl_t ctl,
  output xsbr_pkg::gen_sts_t sts
);

  xsbr_pkg::word_t seed0_r, seed1_r;
  xsbr_pkg::word_t word0_r, word1_r;
  xsbr_pkg::word_t seed0_nxt, seed1_nxt;
  xsbr_pkg::word_t word0_nxt, word1_nxt;
  xsbr_pkg::word_t mix_a;

  always_comb begin
    seed0_nxt = seed0_r;
    seed1_nxt = seed1_r;
    word0_nxt = word0_r;
    word1_nxt = word1_r;
    mix_a     = word0_r ^ (word0_r << xsbr_pkg::SHIFT_A);
    if (cfg_we) begin
      case (cfg_addr)
        xsbr_pkg::REG_SEED_ZERO: begin
          seed0_nxt = cfg_wdata;
          word0_nxt = cfg_wdata;
          word1_nxt = seed1_r;
        end
        xsbr_pkg::REG_SEED_ONE: begin
          seed1_nxt = cfg_wdata;
          word0_nxt = seed0_r;
          word1_nxt = cfg_wdata;
        end
        default: begin
        end
      endcase
    end else if (ctl.step) begin
      word0_nxt = word1_r;
      word1_nxt = mix_a ^ word1_r ^ (mix_a >> xsbr_pkg::SHIFT_B)
                  ^ (word1_r >> xsbr_pkg::SHIFT_C);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed0_r <= xsbr_pkg::SEED_ZERO_RST;
      seed1_r <= xsbr_pkg::SEED_ONE_RST;
      word0_r <= xsbr_pkg::SEED_ZERO_RST;
      word1_r <= xsbr_pkg::SEED_ONE_RST;
    end else begin
      seed0_r <= seed0_nxt;
      seed1_r <= seed1_nxt;
      word0_r <= word0_nxt;
      word1_r <= word1_nxt;
    end
  end

  assign sts.sum = word0_r + word1_r;

endmodule

// ===== rtl/xsbr_seq.sv =====
// ---------------------------------------------------------------------------
// xsbr_seq
// Request sequencer: mask, draw, reject and hold the result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module xsbr_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  xsbr_pkg::word_t    in_tdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  output xsbr_pkg::word_t    out_tdata,
  output xsbr_pkg::gen_ctl_t gen_ctl,
  input  xsbr_pkg::gen_sts_t gen_sts
);

  typedef enum logic {
    ST_IDLE,
    ST_DRAW
  } state_t;

  state_t          state_r, state_nxt;
  xsbr_pkg::word_t bound_r, bound_nxt;
  xsbr_pkg::word_t mask_r, mask_nxt;
  logic            zero_r, zero_nxt;
  logic            out_tvalid_r, out_tvalid_nxt;
  xsbr_pkg::word_t out_tdata_r, out_tdata_nxt;
  xsbr_pkg::word_t draw_val;
  logic            keep, slot_free, commit;

  always_comb begin
    draw_val  = mask_r & gen_sts.sum;
    keep      = zero_r || (draw_val <= bound_r);
    slot_free = !out_tvalid_r || out_tready;
    commit    = (state_r == ST_DRAW) && keep && slot_free;

    gen_ctl.step = (state_r == ST_DRAW) && !zero_r && (!keep || slot_free);

    state_nxt      = state_r;
    bound_nxt      = bound_r;
    mask_nxt       = mask_r;
    zero_nxt       = zero_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          bound_nxt = in_tdata;
          mask_nxt  = xsbr_pkg::length_mask(in_tdata);
          zero_nxt  = (in_tdata == '0);
          state_nxt = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (commit) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = draw_val;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      zero_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      zero_r       <= zero_nxt;
    end
    bound_r     <= bound_nxt;
    mask_r      <= mask_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `XSBR_ASSERT(a_result_in_range, commit |-> (draw_val <= bound_r), "result above bound")
  `XSBR_ASSERT(a_zero_no_step, (state_r == ST_DRAW && zero_r) |-> !gen_ctl.step, "zero bound stepped generator")
  `XSBR_ASSERT(a_step_only_draw, gen_ctl.step |-> (state_r == ST_DRAW), "generator stepped while idle")
  `XSBR_ASSERT(a_commit_shows, commit |=> (out_tvalid_r && state_r == ST_IDLE), "result not presented")

endmodule

// ===== rtl/xorshift128p_bounded_random_core.sv =====
// ---------------------------------------------------------------------------
// xorshift128p_bounded_random_core
// Uniform random value in 0..upper_bound from a xorshift128+ generator,
// masked to the bound's bit length with rejection of oversize draws.
// ---------------------------------------------------------------------------
//  Channel   Direction  Carries
//  in_*      slave      upper_bound (64 bits)
//  out_*     master     random_value (64 bits)
//  cfg_*     write      addr 0: seed_word_zero, addr 1: seed_word_one
//
//  An item is taken in, then drawn until a draw is kept; the single
//  generator step unit gives one draw per cycle unless a kept draw waits.
//  A zero bound leaves the generator untouched.
//  Reset loads seeds 1 and 0 into the generator; a seed write reloads both.
//  A result waiting at the output holds a kept draw; rejects still redraw.
// ---------------------------------------------------------------------------
module xorshift128p_bounded_random_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  xsbr_pkg::word_t    in_tdata,   // [63:0] upper_bound
  output logic               out_tvalid,
  input  logic               out_tready,
  output xsbr_pkg::word_t    out_tdata,  // [63:0] random_value
  input  logic               cfg_we,
  input  xsbr_pkg::cfg_idx_t cfg_addr,
  input  xsbr_pkg::word_t    cfg_wdata
);

  xsbr_pkg::gen_ctl_t gen_ctl;
  xsbr_pkg::gen_sts_t gen_sts;

  xsbr_gen u_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .ctl       (gen_ctl),
    .sts       (gen_sts)
  );

  xsbr_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .gen_ctl    (gen_ctl),
    .gen_sts    (gen_sts)
  );

endmodule

// ===== dv/xorshift128p_bounded_random_checker.sv =====
// ---------------------------------------------------------------------------
// xorshift128p_bounded_random_checker
// Watches the bound, result and seed-write ports of the bounded random core.
// Keeps its own copy of the seeds and generator words, predicts each result
// as bound requests transfer in, and compares the results in order.
// ---------------------------------------------------------------------------
module xorshift128p_bounded_random_checker
  import xsbr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_tready,
  input  word_t    in_tdata,   // [63:0] upper_bound
  input  logic     out_tvalid,
  input  logic     out_tready,
  input  word_t    out_tdata,  // [63:0] random_value
  input  logic     cfg_we,
  input  cfg_idx_t cfg_addr,
  input  word_t    cfg_wdata,
  output int       fail_count,
  output int       pending_count,
  output int       result_count,
  output int       redraw_count
);

  word_t seed_zero_q;
  word_t seed_one_q;
  word_t gen_zero;
  word_t gen_one;
  word_t value_q[$];
  int    fails   = 0;
  int    results = 0;
  int    redraws = 0;

  function automatic word_t gen_advance();
    word_t x;
    word_t y;
    word_t sum;
    x        = gen_zero;
    y        = gen_one;
    sum      = x + y;
    x        = x ^ (x << SHIFT_A);
    gen_zero = y;
    gen_one  = x ^ y ^ (x >> SHIFT_B) ^ (y >> SHIFT_C);
    return sum;
  endfunction

  function automatic word_t span_mask(word_t bound);
    word_t m;
    m = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if ((bound >> i) != '0) m[i] = 1'b1;
    end
    return m;
  endfunction

  function automatic word_t bounded_value(word_t bound);
    word_t m;
    word_t v;
    if (bound == '0) return '0;
    m = span_mask(bound);
    v = gen_advance() & m;
    while (v > bound) begin
      redraws++;
      v = gen_advance() & m;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      seed_zero_q = SEED_ZERO_RST;
      seed_one_q  = SEED_ONE_RST;
      gen_zero    = SEED_ZERO_RST;
      gen_one     = SEED_ONE_RST;
      value_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_SEED_ZERO: seed_zero_q = cfg_wdata;
          REG_SEED_ONE:  seed_one_q  = cfg_wdata;
          default: begin
          end
        endcase
        gen_zero = seed_zero_q;
        gen_one  = seed_one_q;
      end
      if (out_tvalid && out_tready) begin
        results++;
        if (value_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected random_value %h, expected none", $time, out_tdata);
        end else begin
          word_t want;
          want = value_q.pop_front();
          if (want !== out_tdata) begin
            fails++;
            $display("%0t: random_value expected %h, actual %h", $time, want, out_tdata);
          end
        end
      end
      if (in_tvalid && in_tready) value_q.push_back(bounded_value(in_tdata));
    end
    fail_count    <= fails;
    pending_count <= value_q.size();
    result_count  <= results;
    redraw_count  <= redraws;
  end

endmodule

// ===== dv/xorshift128p_bounded_random_core_tb.sv =====
// ---------------------------------------------------------------------------
// xorshift128p_bounded_random_core_tb
// Drives bound requests into the bounded random core under several seed
// settings, with random idling on both channels and a long output stall;
// the checker beside the core predicts and compares every result.
// ---------------------------------------------------------------------------
module xorshift128p_bounded_random_core_tb;
  import xsbr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 176;

  logic     clk        = 1'b0;
  logic     rst_n      = 1'b0;
  logic     in_tvalid  = 1'b0;
  logic     in_tready;
  word_t    in_tdata   = '0;   // [63:0] upper_bound
  logic     out_tvalid;
  logic     out_tready = 1'b0;
  word_t    out_tdata;         // [63:0] random_value
  logic     cfg_we     = 1'b0;
  cfg_idx_t cfg_addr   = REG_SEED_ZERO;
  word_t    cfg_wdata  = '0;

  int fail_count;
  int pending_count;
  int result_count;
  int redraw_count;
  int cycle_count = 0;
  int settings    = 1;
  bit quiet       = 1'b0;
  bit hold_req    = 1'b0;

  word_t corner_bounds[20] = '{
    64'h0, 64'h1, 64'h2, 64'h3, 64'h4, 64'h7, 64'h8, 64'hFF, 64'h100,
    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0001_0000_0000,
    64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
    64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
    64'hFFFF_FFFF_FFFF_FFFF, 64'h1
  };

  always #5 clk = ~clk;

  xorshift128p_bounded_random_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  xorshift128p_bounded_random_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count),
    .redraw_count  (redraw_count)
  );

  function automatic word_t rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic word_t pick_bound();
    word_t r;
    int unsigned sel;
    r   = rand64();
    sel = $urandom_range(0, 19);
    case (sel)
      0:       return '0;
      1:       return '1;
      2, 3:    return word_t'($urandom_range(1, 16));
      4:       return word_t'(1) << $urandom_range(0, 63);
      5:       return (word_t'(1) << $urandom_range(1, 63)) - 1;
      6, 7:    return (word_t'(1) << $urandom_range(0, 63)) + 1;
      8, 9, 10, 11, 12, 13: return r >> $urandom_range(0, 63);
      default: return r;
    endcase
  endfunction

  task automatic send_bound(word_t b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering and let every pending result come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_seed(cfg_idx_t idx, word_t v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic seed_phase(word_t s0, word_t s1, int n);
    drain();
    write_seed(REG_SEED_ZERO, s0);
    write_seed(REG_SEED_ONE, s1);
    settings++;
    repeat (n) send_bound(pick_bound());
  endtask

  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_bounds[i]) send_bound(corner_bounds[i]);

    // Hold off the output so the core backs up onto the input.
    drain();
    write_seed(REG_SEED_ZERO, rand64());
    write_seed(REG_SEED_ONE, rand64());
    settings++;
    hold_req = 1'b1;
    repeat (24) send_bound(pick_bound());
    repeat (PHASE_ITEMS - 24) send_bound(pick_bound());

    // Reload through the second seed alone, with a full pause midway.
    drain();
    write_seed(REG_SEED_ONE, rand64());
    settings++;
    repeat (PHASE_ITEMS / 2) send_bound(pick_bound());
    drain();
    repeat (PHASE_ITEMS / 2) send_bound(pick_bound());

    seed_phase('1, '1, PHASE_ITEMS);
    seed_phase('0, '0, PHASE_ITEMS);
    seed_phase('0, '1, PHASE_ITEMS);
    seed_phase('1, '0, PHASE_ITEMS);
    quiet = 1'b1;
    seed_phase(rand64(), rand64(), PHASE_ITEMS);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d bounded draws over %0d seed settings, %0d rejected redraws",
             result_count, settings, redraw_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
